>>> rtl/core/bba_pkg.sv
// Shared types, constants and helpers for the buddy block allocator.
// No dependencies; bba_bitop and the core in rtl/core import it.
`default_nettype none
package bba_pkg;

  localparam int MIN_BLOCK = 64;
  localparam int LOG_MIN   = 6;
  localparam int LEVELS    = 11;
  localparam int HEADER    = 16;
  localparam int TOP_LEVEL = LEVELS - 1;

  localparam int LVL_W     = 4;
  localparam int IDX_W     = LEVELS - 1;        // block index at level 0
  localparam int OWN_DEPTH = 1 << (LEVELS - 1);
  localparam int OWN_AW    = LEVELS - 1;
  localparam int OWN_W     = LVL_W + 1;

  // Free map is held as 32-bit words, one or more per level.
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int FM_WORDS  = 68;
  localparam int FM_AW     = 7;
  localparam int WIDX_W    = IDX_W - POS_W;

  localparam logic [FM_AW-1:0] FM_BASE [LEVELS] =
    '{7'd0, 7'd32, 7'd48, 7'd56, 7'd60, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67};
  localparam logic [WIDX_W-1:0] FM_LAST [LEVELS] =
    '{5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BOP_TAKE = 2'd0,
    BOP_CLR  = 2'd1,
    BOP_SET  = 2'd2
  } bop_t;

  typedef struct packed {
    logic              any;
    logic [POS_W-1:0]  low;
    logic              bit_val;
    logic [WORD_W-1:0] word_out;
  } bop_res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_ROOT, S_IDLE, S_DECODE,
    S_A_RD, S_A_CHK, S_SP_RD, S_SP_WR, S_OWN_WR,
    S_F_OWN, S_F_CHK_RD, S_F_CHK, S_F_SET_RD, S_F_SET_WR,
    S_DONE
  } st_t;

  // Word address of block i at level lvl.
  function automatic logic [FM_AW-1:0] fm_addr(input logic [LVL_W-1:0] lvl,
                                               input logic [IDX_W-1:0] i);
    logic [FM_AW-1:0] base;
    base = '0;
    if (lvl <= LVL_W'(TOP_LEVEL)) begin
      base = FM_BASE[lvl];
    end
    return base + FM_AW'(i[IDX_W-1:POS_W]);
  endfunction

  function automatic logic [WIDX_W-1:0] fm_last(input logic [LVL_W-1:0] lvl);
    logic [WIDX_W-1:0] r;
    r = '0;
    if (lvl <= LVL_W'(TOP_LEVEL)) begin
      r = FM_LAST[lvl];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/bba_bitop.sv
// Shared bit unit over one free-map word: lowest-set search, test, set, clear.
// Depends on bba_pkg.
`default_nettype none
module bba_bitop (
  input  wire logic [31:0]       word_in,
  input  wire logic [4:0]        pos,
  input  wire bba_pkg::bop_t     op,
  output      bba_pkg::bop_res_t res
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mask;

  always_comb begin
    res.any = |word_in;
    res.low = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word_in[b]) begin
        res.low = POS_W'(b);
      end
    end
    res.bit_val = word_in[pos];
    case (op)
      BOP_TAKE: mask = WORD_W'(1) << res.low;
      BOP_CLR:  mask = WORD_W'(1) << pos;
      BOP_SET:  mask = WORD_W'(1) << pos;
      default:  mask = '0;
    endcase
    if (op == BOP_SET) begin
      res.word_out = word_in | mask;
    end else begin
      res.word_out = word_in & ~mask;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/buddy_block_allocator_core.sv
// Buddy block allocator core: sequencer, free-map and owner RAMs, bit unit.
// Depends on bba_pkg, bba_ram and bba_bitop.
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+------------------------------
//  item in   | action, request_size, address         | taken when start && !busy
//  result    | status, address_out, level_out        | one cycle, marked by done
//  config    | cfg_wdata (pool level)                | written when cfg_we
//
// An allocate decodes the item, reads and checks each free-map word it scans, reads
// and writes the free map for each split, then writes the owner table before done.
// An allocate that is too large for the pool goes from decode straight to done.
// A free reads the owner table, reads and checks each buddy, then reads and writes
// the merged block's word. A null or malformed free goes from decode to done; an
// unowned one reads the owner table first. Idle follows in the cycle after done.
// The free map is read one 32-bit word at a time, so scanning a level costs that
// level's full word count (32 at level 0) whatever the pool level. The worst
// allocate at level 0 scans 68 words and splits 10 times.
// Reset, and every pool_level write, runs a clearing pass over both RAMs (busy high)
// before the first item is taken.
// The receiver cannot stall: done is high for exactly one cycle per item.
`default_nettype none
module buddy_block_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        action,
  input  wire logic [15:0] request_size,
  input  wire logic [15:0] address,
  output      logic        done,
  output      logic [1:0]  status,
  output      logic [15:0] address_out,
  output      logic [3:0]  level_out,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);
  import bba_pkg::*;

  st_t state, state_next;

  logic [LVL_W-1:0]  pool_level;
  logic [OWN_AW-1:0] clr;
  logic              act_q;
  logic [15:0]       size_q, addr_q;
  logic [LVL_W-1:0]  lvl, want;
  logic [IDX_W-1:0]  idx;
  logic [WIDX_W-1:0] w;
  logic [OWN_AW-1:0] slot;
  status_t           res_status;
  logic [15:0]       res_addr;
  logic [LVL_W-1:0]  res_level;

  // Decode of the captured item.
  logic [16:0]       need;
  logic [LVL_W-1:0]  want_c;
  logic              fit_c, alloc_ok;
  logic [15:0]       off_c;
  logic              free_bad;
  logic [OWN_AW-1:0] slot_c;

  // RAM ports.
  logic              fm_we, own_we;
  logic [FM_AW-1:0]  fm_wa, fm_ra;
  logic [WORD_W-1:0] fm_wd, fm_rd;
  logic [OWN_AW-1:0] own_wa, own_ra;
  logic [OWN_W-1:0]  own_wd, own_rd;

  // Bit unit.
  bop_t              bu_op;
  logic [POS_W-1:0]  bu_pos;
  bop_res_t          bu;

  logic [IDX_W-1:0]  found_idx, buddy_idx, split_idx;
  logic [OWN_AW-1:0] alloc_slot;

  bba_ram #(.WIDTH(WORD_W), .DEPTH(FM_WORDS)) u_free_map (
    .clk(clk), .we(fm_we), .waddr(fm_wa), .wdata(fm_wd), .raddr(fm_ra), .rdata(fm_rd)
  );

  bba_ram #(.WIDTH(OWN_W), .DEPTH(OWN_DEPTH)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd), .raddr(own_ra), .rdata(own_rd)
  );

  bba_bitop u_bitop (.word_in(fm_rd), .pos(bu_pos), .op(bu_op), .res(bu));

  assign found_idx  = IDX_W'({w, bu.low});
  assign buddy_idx  = idx ^ IDX_W'(1);
  assign split_idx  = idx | IDX_W'(1);
  assign alloc_slot = OWN_AW'(idx << want);

  // Allocate sizing: raise to the minimum block, add the header, pick level.
  always_comb begin
    need   = ((size_q < 16'(MIN_BLOCK)) ? 17'(MIN_BLOCK) : 17'(size_q)) + 17'(HEADER);
    want_c = '0;
    fit_c  = 1'b0;
    for (int l = TOP_LEVEL; l >= 0; l--) begin
      if (32'(need) <= 32'(MIN_BLOCK << l)) begin
        want_c = LVL_W'(l);
        fit_c  = 1'b1;
      end
    end
    alloc_ok = fit_c && (want_c <= pool_level);
  end

  // Free address check: above the header, aligned, inside the owner table.
  always_comb begin
    off_c    = addr_q - 16'(HEADER);
    free_bad = (addr_q < 16'(HEADER)) || (off_c[LOG_MIN-1:0] != '0) ||
               ((off_c >> LOG_MIN) >= 16'(OWN_DEPTH));
    slot_c   = OWN_AW'(off_c >> LOG_MIN);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (clr == OWN_AW'(OWN_DEPTH - 1)) state_next = S_ROOT;
      S_ROOT:     state_next = S_IDLE;
      S_IDLE:     if (start) state_next = S_DECODE;
      S_DECODE: begin
        if (act_q) begin
          state_next = (addr_q == '0 || free_bad) ? S_DONE : S_F_OWN;
        end else begin
          state_next = alloc_ok ? S_A_RD : S_DONE;
        end
      end
      S_A_RD:     state_next = S_A_CHK;
      S_A_CHK: begin
        if (bu.any) begin
          state_next = (lvl == want) ? S_OWN_WR : S_SP_RD;
        end else if (w == fm_last(lvl) && lvl == pool_level) begin
          state_next = S_DONE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_SP_RD:    state_next = S_SP_WR;
      S_SP_WR:    state_next = (lvl == want) ? S_OWN_WR : S_SP_RD;
      S_OWN_WR:   state_next = S_DONE;
      S_F_OWN:    state_next = own_rd[OWN_W-1] ? S_F_CHK_RD : S_DONE;
      S_F_CHK_RD: state_next = (lvl < pool_level) ? S_F_CHK : S_F_SET_RD;
      S_F_CHK:    state_next = bu.bit_val ? S_F_CHK_RD : S_F_SET_RD;
      S_F_SET_RD: state_next = S_F_SET_WR;
      S_F_SET_WR: state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Outputs of the sequencer: RAM ports and bit unit control.
  always_comb begin
    fm_we  = 1'b0;
    fm_wa  = fm_addr(lvl, idx);
    fm_wd  = bu.word_out;
    fm_ra  = fm_addr(lvl, idx);
    own_we = 1'b0;
    own_wa = slot;
    own_wd = '0;
    own_ra = slot_c;
    bu_op  = BOP_SET;
    bu_pos = idx[POS_W-1:0];
    case (state)
      S_CLEAR: begin
        own_we = 1'b1;
        own_wa = clr;
        fm_we  = (clr < OWN_AW'(FM_WORDS));
        fm_wa  = clr[FM_AW-1:0];
        fm_wd  = '0;
      end
      S_ROOT: begin
        fm_we = 1'b1;
        fm_wa = fm_addr(pool_level, '0);
        fm_wd = WORD_W'(1);
      end
      S_A_RD: begin
        fm_ra = fm_addr(lvl, IDX_W'({w, POS_W'(0)}));
      end
      S_A_CHK: begin
        bu_op = BOP_TAKE;
        fm_we = bu.any;
        fm_wa = fm_addr(lvl, IDX_W'({w, POS_W'(0)}));
      end
      S_SP_RD: begin
        fm_ra = fm_addr(lvl, split_idx);
      end
      S_SP_WR: begin
        bu_pos = split_idx[POS_W-1:0];
        fm_we  = 1'b1;
        fm_wa  = fm_addr(lvl, split_idx);
      end
      S_OWN_WR: begin
        own_we = 1'b1;
        own_wa = alloc_slot;
        own_wd = {1'b1, want};
      end
      S_F_OWN: begin
        own_we = own_rd[OWN_W-1];
      end
      S_F_CHK_RD: begin
        fm_ra = fm_addr(lvl, buddy_idx);
      end
      S_F_CHK: begin
        bu_op  = BOP_CLR;
        bu_pos = buddy_idx[POS_W-1:0];
        fm_we  = bu.bit_val;
        fm_wa  = fm_addr(lvl, buddy_idx);
      end
      S_F_SET_WR: begin
        fm_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      pool_level <= LVL_W'(TOP_LEVEL);
    end else if (cfg_we) begin
      // Rewriting the pool level empties the pool: restart the clearing pass.
      pool_level <= (cfg_wdata > LVL_W'(TOP_LEVEL)) ? LVL_W'(TOP_LEVEL) : cfg_wdata;
      state      <= S_CLEAR;
      clr        <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr <= clr + OWN_AW'(1);
        S_IDLE: begin
          if (start) begin
            act_q  <= action;
            size_q <= request_size;
            addr_q <= address;
          end
        end
        S_DECODE: begin
          want      <= want_c;
          lvl       <= want_c;
          w         <= '0;
          slot      <= slot_c;
          res_addr  <= '0;
          res_level <= '0;
          if (act_q) begin
            res_status <= (addr_q == '0) ? ST_NULL : ST_NOT_ALLOC;
          end else begin
            res_status <= ST_NO_SPACE;
          end
        end
        S_A_CHK: begin
          if (bu.any) begin
            if (lvl == want) begin
              idx <= found_idx;
            end else begin
              idx <= found_idx << 1;
              lvl <= lvl - LVL_W'(1);
            end
          end else if (w == fm_last(lvl)) begin
            // Level exhausted: climb to the next level.
            lvl <= lvl + LVL_W'(1);
            w   <= '0;
          end else begin
            w <= w + WIDX_W'(1);
          end
        end
        S_SP_WR: begin
          if (lvl != want) begin
            lvl <= lvl - LVL_W'(1);
            idx <= idx << 1;
          end
        end
        S_OWN_WR: begin
          res_status <= ST_OK;
          res_addr   <= 16'({alloc_slot, LOG_MIN'(0)}) + 16'(HEADER);
          res_level  <= want;
        end
        S_F_OWN: begin
          want <= own_rd[LVL_W-1:0];
          lvl  <= own_rd[LVL_W-1:0];
          idx  <= IDX_W'(slot >> own_rd[LVL_W-1:0]);
        end
        S_F_CHK: begin
          if (bu.bit_val) begin
            idx <= idx >> 1;
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_F_SET_WR: begin
          res_status <= ST_OK;
          res_addr   <= '0;
          res_level  <= want;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign status      = res_status;
  assign address_out = res_addr;
  assign level_out   = res_level;

  // An accepted item always leaves the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A failed or free result never carries an address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> address_out == '0)
    else $error("non-ok result carries an address");

  // A successful result names a level inside the pool.
  a_level_in_pool: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> level_out <= pool_level)
    else $error("result level above pool level");

  // No result is shown during the clearing pass.
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !done)
    else $error("result during clearing pass");

endmodule
`default_nettype wire

>>> dv/buddy_block_allocator_core_tb.sv
// Self-checking testbench for buddy_block_allocator_core: drives allocate and free
// items, predicts every result with its own buddy-allocator model and compares.
// Depends on bba_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_core_tb;
  import bba_pkg::*;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam int   NODES     = (1 << LEVELS) - 1;

  typedef struct packed {
    status_t     st;
    logic [15:0] addr;
    logic [3:0]  lvl;
  } alloc_result_t;

  // Shadow allocator: holds its own free map and owner table, predicts each
  // result when the item is accepted and compares results in order.
  class alloc_scoreboard;
    bit            free_bits [NODES];
    logic [4:0]    owner [OWN_DEPTH];
    int unsigned   pool_lvl;
    alloc_result_t pending [$];
    logic [15:0]   live [$];
    int unsigned   mismatches;
    int unsigned   strays;

    function int unsigned node(int unsigned lvl, int unsigned idx);
      return ((1 << (TOP_LEVEL - lvl)) - 1) + idx;
    endfunction

    function void set_pool(logic [3:0] v);
      pool_lvl = (v > TOP_LEVEL) ? TOP_LEVEL : v;
      foreach (free_bits[k]) free_bits[k] = 0;
      foreach (owner[k]) owner[k] = '0;
      free_bits[node(pool_lvl, 0)] = 1;
      live.delete();
    endfunction

    function alloc_result_t predict_alloc(logic [15:0] size);
      alloc_result_t r;
      int unsigned   need, blk, want, lvl, i;
      int            idx;
      r = '{ST_NO_SPACE, 16'd0, 4'd0};
      need = ((size < MIN_BLOCK) ? MIN_BLOCK : size) + HEADER;
      blk = MIN_BLOCK;
      want = 0;
      idx = -1;
      while (blk < need && want < TOP_LEVEL) begin
        blk = blk << 1;
        want++;
      end
      if (blk < need || want > pool_lvl) return r;
      for (lvl = want; lvl <= pool_lvl; lvl++) begin
        for (int unsigned k = 0; k < (1 << (pool_lvl - lvl)); k++) begin
          if (free_bits[node(lvl, k)]) begin
            idx = k;
            break;
          end
        end
        if (idx >= 0) break;
      end
      if (idx < 0) return r;
      i = idx;
      free_bits[node(lvl, i)] = 0;
      // split down, keep the lower half, release the upper one
      while (lvl > want) begin
        lvl--;
        i = i << 1;
        free_bits[node(lvl, i + 1)] = 1;
      end
      i = i << want;
      owner[i] = {1'b1, 4'(want)};
      r = '{ST_OK, 16'(i * MIN_BLOCK + HEADER), 4'(want)};
      live.push_back(r.addr);
      return r;
    endfunction

    function alloc_result_t predict_free(logic [15:0] addr);
      alloc_result_t r;
      int unsigned   slot, lvl, orig, i;
      r = '{ST_NOT_ALLOC, 16'd0, 4'd0};
      if (addr == 0) return '{ST_NULL, 16'd0, 4'd0};
      if (addr < HEADER || ((addr - HEADER) % MIN_BLOCK) != 0) return r;
      slot = (addr - HEADER) / MIN_BLOCK;
      if (slot >= OWN_DEPTH || !owner[slot][4]) return r;
      orig = owner[slot][3:0];
      owner[slot] = '0;
      lvl = orig;
      i = slot >> lvl;
      // merge with free buddies upward
      while (lvl < pool_lvl && free_bits[node(lvl, i ^ 1)]) begin
        free_bits[node(lvl, i ^ 1)] = 0;
        i = i >> 1;
        lvl++;
      end
      free_bits[node(lvl, i)] = 1;
      foreach (live[k]) begin
        if (live[k] == addr) begin
          live.delete(k);
          break;
        end
      end
      return '{ST_OK, 16'd0, 4'(orig)};
    endfunction

    function void note_item(logic act, logic [15:0] size, logic [15:0] addr);
      pending.push_back(act == ACT_FREE ? predict_free(addr) : predict_alloc(size));
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] addr, logic [3:0] lvl);
      alloc_result_t e;
      if (pending.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10)
          $display("unexpected result: status %0d address %0d level %0d", st, addr, lvl);
        return;
      end
      e = pending.pop_front();
      if (st !== e.st || addr !== e.addr || lvl !== e.lvl) begin
        mismatches++;
        if (strays + mismatches <= 10)
          $display("mismatch: exp status %0d addr %0d level %0d, got %0d %0d %0d",
                   e.st, e.addr, e.lvl, st, addr, lvl);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = ACT_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] address = '0;
  logic        done;
  logic [1:0]  status;
  logic [15:0] address_out;
  logic [3:0]  level_out;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  alloc_scoreboard sb;

  buddy_block_allocator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .request_size(request_size), .address(address),
    .done(done), .status(status), .address_out(address_out), .level_out(level_out),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Results cannot be held off: take every strobed result as it comes.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(status, address_out, level_out);
    end
  end

  // Present one item and hold it until the block takes it. Busy is read at the
  // falling edge, where it is stable, to decide the following rising edge.
  task automatic send_item(logic act, logic [15:0] size, logic [15:0] addr);
    logic was_busy;
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    request_size <= size;
    address <= addr;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    sb.note_item(act, size, addr);
  endtask

  // Drop start for a random stretch: mostly short, now and then long.
  task automatic idle_gap();
    int unsigned n;
    if ($urandom_range(0, 2) == 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Wait until every result has come, then allow the longest walk to settle.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
  endtask

  task automatic write_pool(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.set_pool(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [15:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 48 || (pick < 88 && sb.live.size() == 0)) begin
      case ($urandom_range(0, 9))
        0: size = 16'($urandom_range(0, 65535));
        1, 2: size = 16'($urandom_range(0, 4096));
        default: size = 16'($urandom_range(0, 400));
      endcase
      send_item(ACT_ALLOC, size, 16'($urandom));
    end else if (pick < 88) begin
      send_item(ACT_FREE, 16'($urandom), sb.live[$urandom_range(0, sb.live.size() - 1)]);
    end else begin
      // noise: null, stale slot, misaligned or wild address
      case ($urandom_range(0, 3))
        0: send_item(ACT_FREE, 16'($urandom), 16'd0);
        1: send_item(ACT_FREE, 16'($urandom), 16'($urandom_range(0, 1023) * MIN_BLOCK + HEADER));
        2: send_item(ACT_FREE, 16'($urandom), 16'($urandom_range(0, 1023) * MIN_BLOCK + 17));
        default: send_item(ACT_FREE, 16'($urandom), 16'($urandom));
      endcase
    end
    idle_gap();
  endtask

  initial begin
    logic [3:0] levels [6] = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd6, 4'd10};
    int unsigned counts [6] = '{120, 15, 260, 30, 120, 100};
    sb = new();
    sb.set_pool(4'd10);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: size extremes, header boundary, every free outcome.
    send_item(ACT_ALLOC, 16'd0, 16'd0);
    send_item(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
    send_item(ACT_ALLOC, 16'd48, 16'd0);
    send_item(ACT_ALLOC, 16'd49, 16'd0);
    send_item(ACT_ALLOC, 16'd65520, 16'd0);
    send_item(ACT_ALLOC, 16'd4080, 16'd0);
    send_item(ACT_FREE, 16'hFFFF, 16'd0);
    send_item(ACT_FREE, 16'd0, 16'd15);
    send_item(ACT_FREE, 16'd0, 16'd17);
    send_item(ACT_FREE, 16'd0, 16'hFFFF);
    send_item(ACT_FREE, 16'd0, 16'd16 + 16'd64 * 16'd900);
    send_item(ACT_FREE, 16'd0, 16'd16);
    send_item(ACT_FREE, 16'd0, 16'd16);
    while (sb.live.size() != 0) send_item(ACT_FREE, 16'd0, sb.live[0]);
    send_item(ACT_ALLOC, 16'd65519, 16'd0);
    send_item(ACT_ALLOC, 16'd1, 16'd0);

    foreach (levels[p]) begin
      write_pool(levels[p]);
      for (int unsigned n = 0; n < counts[p]; n++) begin
        random_item();
        // hold off now and then until the block has answered everything
        if (n % 97 == 50) drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
